// File: rtl/core/allc_pkg.sv
// ----------------------------------------------------------------------------
// allc_pkg
// shared widths, code points, constants and types of the lux converter
// ----------------------------------------------------------------------------
package allc_pkg;

	// fraction bits of the illuminance result (6 to 16)
	localparam int FRAC_BITS = 10;

	// field widths
	localparam int RAW_W  = 16;
	localparam int GAIN_W = 2;
	localparam int TIME_W = 4;
	localparam int LUX_W  = 37;
	localparam int SH_W   = 4;

	// linear front end: scaled count, q32 product, q8 polynomial input
	localparam int SCL_W = RAW_W + 9;
	localparam int K_W   = 24;
	localparam int P_W   = SCL_W + K_W;
	localparam int X_W   = P_W - 24;
	localparam int LIN_W = P_W + 1 - (32 - FRAC_BITS);

	// horner cells
	localparam int OPD_W  = 29;
	localparam int PROD_W = X_W + 1 + OPD_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int COEF_W = 36;
	localparam int AMT_W  = 5;
	localparam int STEP_W = 2;
	localparam int N_STEP = 4;
	localparam int Y_W    = 53;
	localparam int Y_DROP = 24 - FRAC_BITS;

	// gain codes
	localparam logic [GAIN_W-1:0] GAIN_X1   = 2'd0;
	localparam logic [GAIN_W-1:0] GAIN_X2   = 2'd1;
	localparam logic [GAIN_W-1:0] GAIN_X1_8 = 2'd2;
	localparam logic [GAIN_W-1:0] GAIN_X1_4 = 2'd3;

	// integration time codes
	localparam logic [TIME_W-1:0] IT_100MS = 4'd0;
	localparam logic [TIME_W-1:0] IT_200MS = 4'd1;
	localparam logic [TIME_W-1:0] IT_400MS = 4'd2;
	localparam logic [TIME_W-1:0] IT_800MS = 4'd3;
	localparam logic [TIME_W-1:0] IT_50MS  = 4'd8;
	localparam logic [TIME_W-1:0] IT_25MS  = 4'd12;

	// horner step codes
	localparam logic [STEP_W-1:0] STEP_A = 2'd0;
	localparam logic [STEP_W-1:0] STEP_B = 2'd1;
	localparam logic [STEP_W-1:0] STEP_C = 2'd2;
	localparam logic [STEP_W-1:0] STEP_Y = 2'd3;

	// 0.0036 in q32
	localparam logic [K_W-1:0] K_LIN = 24'd15461882;
	// 1000 lux in q32
	localparam logic [P_W-1:0] THRESH = {{(P_W-10){1'b0}}, 10'd1000} << 32;
	localparam logic [P_W:0] LIN_HALF = {{P_W{1'b0}}, 1'b1} << (31 - FRAC_BITS);
	localparam logic [Y_W:0] Y_HALF   = {{Y_W{1'b0}}, 1'b1} << (23 - FRAC_BITS);

	// polynomial coefficients
	localparam logic signed [ACC_W-1:0]  C4_Q = 56'sd11092950;
	localparam logic signed [COEF_W-1:0] C3_Q = -36'sd2643726;
	localparam logic signed [COEF_W-1:0] C2_Q = 36'sd22936910578;
	localparam logic signed [COEF_W-1:0] C1_Q = 36'sd4304845721;

	typedef struct packed {
		logic ok;
		logic [SH_W-1:0] sh;
	} shift_t;

	// info that rides along with a request through the cells
	typedef struct packed {
		logic ok;
		logic corr;
		logic [LIN_W-1:0] lin;
	} side_t;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic signed [ACC_W-1:0] acc;
		side_t side;
	} cell_t;

	function automatic logic [SH_W-1:0] gain_shift(input logic [GAIN_W-1:0] code);
		logic [SH_W-1:0] s;
		unique case (code)
			GAIN_X1:   s = 4'd1;
			GAIN_X2:   s = 4'd0;
			GAIN_X1_8: s = 4'd4;
			GAIN_X1_4: s = 4'd3;
			default:   s = 4'd0;
		endcase
		return s;
	endfunction

	function automatic shift_t time_shift(input logic [TIME_W-1:0] code);
		shift_t r;
		r.ok = 1'b1;
		unique case (code)
			IT_100MS: r.sh = 4'd3;
			IT_200MS: r.sh = 4'd2;
			IT_400MS: r.sh = 4'd1;
			IT_800MS: r.sh = 4'd0;
			IT_50MS:  r.sh = 4'd4;
			IT_25MS:  r.sh = 4'd5;
			default: begin
				r.ok = 1'b0;
				r.sh = 4'd0;
			end
		endcase
		return r;
	endfunction

	function automatic logic signed [COEF_W-1:0] step_coef(input logic [STEP_W-1:0] step);
		logic signed [COEF_W-1:0] c;
		unique case (step)
			STEP_A:  c = C3_Q;
			STEP_B:  c = C2_Q;
			STEP_C:  c = C1_Q;
			STEP_Y:  c = '0;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [AMT_W-1:0] step_pre(input logic [STEP_W-1:0] step);
		logic [AMT_W-1:0] a;
		unique case (step)
			STEP_A:  a = 5'd24;
			STEP_B:  a = 5'd8;
			STEP_C:  a = 5'd8;
			STEP_Y:  a = 5'd0;
			default: a = 5'd0;
		endcase
		return a;
	endfunction

	function automatic logic [AMT_W-1:0] step_post(input logic [STEP_W-1:0] step);
		logic [AMT_W-1:0] a;
		unique case (step)
			STEP_A:  a = 5'd0;
			STEP_B:  a = 5'd16;
			STEP_C:  a = 5'd16;
			STEP_Y:  a = 5'd0;
			default: a = 5'd0;
		endcase
		return a;
	endfunction

	function automatic logic step_clamp(input logic [STEP_W-1:0] step);
		logic c;
		unique case (step)
			STEP_A:  c = 1'b0;
			STEP_B:  c = 1'b1;
			STEP_C:  c = 1'b1;
			STEP_Y:  c = 1'b0;
			default: c = 1'b0;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/allc_front.sv
// ----------------------------------------------------------------------------
// allc_front
// code decode, power-of-two scaling, q32 linear product and threshold check
// ----------------------------------------------------------------------------
module allc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic raw_valid,
	output logic raw_stall,
	input  logic [allc_pkg::RAW_W-1:0] raw_count,
	input  logic [allc_pkg::GAIN_W-1:0] gain_code,
	input  logic [allc_pkg::TIME_W-1:0] time_code,
	output logic out_valid,
	input  logic out_rdy,
	output allc_pkg::cell_t out_data
);

	allc_pkg::shift_t ts;
	logic [allc_pkg::SH_W-1:0] sh;
	logic [allc_pkg::SCL_W-1:0] scl;
	logic [allc_pkg::P_W-1:0] prod;
	logic [allc_pkg::P_W:0] lin_sum;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	logic [allc_pkg::SCL_W-1:0] scl_s1;
	logic ok_s1, ok_s2;
	logic [allc_pkg::P_W-1:0] p_s2;
	allc_pkg::cell_t d_s3;

	assign rdy3 = !v_s3 || out_rdy;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign raw_stall = !rdy1;

	// invalid codes force a zero count, which yields a zero lux result
	always_comb begin
		ts = allc_pkg::time_shift(time_code);
		sh = allc_pkg::gain_shift(gain_code) + ts.sh;
		scl = ts.ok ? (allc_pkg::SCL_W'(raw_count) << sh) : '0;
	end

	assign prod = scl_s1 * allc_pkg::K_LIN;
	assign lin_sum = {1'b0, p_s2} + allc_pkg::LIN_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= raw_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && raw_valid) begin
			scl_s1 <= scl;
			ok_s1 <= ts.ok;
		end
		if (rdy2 && v_s1) begin
			p_s2 <= prod;
			ok_s2 <= ok_s1;
		end
		if (rdy3 && v_s2) begin
			d_s3.x <= p_s2[allc_pkg::P_W-1:24];
			d_s3.acc <= allc_pkg::C4_Q;
			d_s3.side.ok <= ok_s2;
			d_s3.side.corr <= (p_s2 > allc_pkg::THRESH);
			d_s3.side.lin <= lin_sum[allc_pkg::P_W:32-allc_pkg::FRAC_BITS];
		end
	end

	assign out_valid = v_s3;
	assign out_data = d_s3;

endmodule

// File: rtl/core/allc_horner_cell.sv
// ----------------------------------------------------------------------------
// allc_horner_cell
// one horner step: acc = post(clamp(floor((x * acc) >> pre) + coef))
// ----------------------------------------------------------------------------
module allc_horner_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic [allc_pkg::STEP_W-1:0] step,
	input  logic in_valid,
	output logic in_rdy,
	input  allc_pkg::cell_t in_data,
	output logic out_valid,
	input  logic out_rdy,
	output allc_pkg::cell_t out_data
);

	logic signed [allc_pkg::PROD_W-1:0] prod;
	logic signed [allc_pkg::ACC_W-1:0] ext;
	logic signed [allc_pkg::ACC_W-1:0] shr;
	logic signed [allc_pkg::ACC_W-1:0] sum;
	logic signed [allc_pkg::ACC_W-1:0] res;
	logic signed [allc_pkg::COEF_W-1:0] coef;
	logic v_q;
	allc_pkg::cell_t d_q;

	assign prod = $signed({1'b0, in_data.x}) * $signed(in_data.acc[allc_pkg::OPD_W-1:0]);

	always_comb begin
		coef = allc_pkg::step_coef(step);
		ext = {prod[allc_pkg::PROD_W-1], prod};
		shr = ext >>> allc_pkg::step_pre(step);
		sum = shr + {{(allc_pkg::ACC_W-allc_pkg::COEF_W){coef[allc_pkg::COEF_W-1]}}, coef};
		if (allc_pkg::step_clamp(step) && sum[allc_pkg::ACC_W-1]) begin
			sum = '0;
		end
		res = sum >>> allc_pkg::step_post(step);
	end

	assign in_rdy = !v_q || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_rdy) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_valid) begin
			d_q.x <= in_data.x;
			d_q.acc <= res;
			d_q.side <= in_data.side;
		end
	end

	assign out_valid = v_q;
	assign out_data = d_q;

endmodule

// File: rtl/core/allc_back.sv
// ----------------------------------------------------------------------------
// allc_back
// result rounding, linear or corrected select, saturation and output register
// ----------------------------------------------------------------------------
module allc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_rdy,
	input  allc_pkg::cell_t in_data,
	output logic lux_valid,
	input  logic lux_stall,
	output logic [allc_pkg::LUX_W-1:0] lux_fixed,
	output logic codes_ok,
	output logic corrected
);

	logic [allc_pkg::Y_W-1:0] y;
	logic [allc_pkg::Y_W:0] yr;
	logic [allc_pkg::LUX_W-1:0] lux;
	logic v_q;
	logic [allc_pkg::LUX_W-1:0] lux_q;
	logic ok_q;
	logic corr_q;

	always_comb begin
		y = in_data.acc[allc_pkg::Y_W-1:0];
		yr = ({1'b0, y} + allc_pkg::Y_HALF) >> allc_pkg::Y_DROP;
		if (!in_data.side.corr) begin
			lux = {{(allc_pkg::LUX_W-allc_pkg::LIN_W){1'b0}}, in_data.side.lin};
		end else if (|yr[allc_pkg::Y_W:allc_pkg::LUX_W]) begin
			lux = '1;
		end else begin
			lux = yr[allc_pkg::LUX_W-1:0];
		end
	end

	assign in_rdy = !v_q || !lux_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_rdy) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_valid) begin
			lux_q <= lux;
			ok_q <= in_data.side.ok;
			corr_q <= in_data.side.corr;
		end
	end

	assign lux_valid = v_q;
	assign lux_fixed = lux_q;
	assign codes_ok = ok_q;
	assign corrected = corr_q;

endmodule

// File: rtl/core/ambient_light_lux_converter_core.sv
// ----------------------------------------------------------------------------
// ambient_light_lux_converter_core
// raw light count to fixed-point lux with quartic correction above 1000 lux
// ----------------------------------------------------------------------------
// usage
// - request channel: raw_valid / raw_stall with raw_count, gain_code and
//   time_code; a request is taken at a rising edge with raw_valid high and
//   raw_stall low
// - result channel: lux_valid / lux_stall with lux_fixed (q.10 by default),
//   codes_ok and corrected; one result per request, in request order
// - path: a request passes three front stages, four horner cells and one
//   output register on its way to the result
// - throughput: one request per cycle while lux_stall is low; every stage holds
//   one request and passes it on whenever the stage after it is ready
// - receiver stall: the output register holds its result; stages behind it
//   keep filling any empty slots, so requests are still taken until the
//   whole chain is full, then raw_stall rises
// - reset (arst_n low): all stage valids clear at once, the chain is empty
//   and ready for a request once reset is released
// - an unknown time code yields zero lux with codes_ok low
// ----------------------------------------------------------------------------
module ambient_light_lux_converter_core (
	input  logic clk,
	input  logic arst_n,
	input  logic raw_valid,
	output logic raw_stall,
	input  logic [allc_pkg::RAW_W-1:0] raw_count,
	input  logic [allc_pkg::GAIN_W-1:0] gain_code,
	input  logic [allc_pkg::TIME_W-1:0] time_code,
	output logic lux_valid,
	input  logic lux_stall,
	output logic [allc_pkg::LUX_W-1:0] lux_fixed,
	output logic codes_ok,
	output logic corrected
);

	// chain links: index 0 is the front end output, index N_STEP the last cell
	logic link_valid [allc_pkg::N_STEP+1];
	logic link_rdy [allc_pkg::N_STEP+1];
	allc_pkg::cell_t link_data [allc_pkg::N_STEP+1];

	// scaling, linear product, threshold compare and linear rounding
	allc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_count (raw_count),
		.gain_code (gain_code),
		.time_code (time_code),
		.out_valid (link_valid[0]),
		.out_rdy   (link_rdy[0]),
		.out_data  (link_data[0])
	);

	// horner chain: a, b, c, then the final multiply by x
	for (genvar i = 0; i < allc_pkg::N_STEP; i++) begin : g_cell
		allc_horner_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (allc_pkg::STEP_W'(i)),
			.in_valid  (link_valid[i]),
			.in_rdy    (link_rdy[i]),
			.in_data   (link_data[i]),
			.out_valid (link_valid[i+1]),
			.out_rdy   (link_rdy[i+1]),
			.out_data  (link_data[i+1])
		);
	end

	// rounding, selection, saturation and the result register
	allc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (link_valid[allc_pkg::N_STEP]),
		.in_rdy    (link_rdy[allc_pkg::N_STEP]),
		.in_data   (link_data[allc_pkg::N_STEP]),
		.lux_valid (lux_valid),
		.lux_stall (lux_stall),
		.lux_fixed (lux_fixed),
		.codes_ok  (codes_ok),
		.corrected (corrected)
	);

endmodule
